[hw/rtl/chl_rti_pkg.sv]
// shared types, constants and the log2 mantissa table of the turbidity index pipeline
package chl_rti_pkg;

  // field widths
  localparam int CHL_W = 16;
  localparam int VAL_W = 24;

  // log2 mantissa table
  localparam int LOG_TABLE_ENTRIES = 256;
  localparam int LOG_IDX_W = $clog2(LOG_TABLE_ENTRIES);
  localparam int LOG_N_W = $clog2(LOG_TABLE_ENTRIES + 1);
  localparam int LOG_Q_W = 16;

  // front end formats
  localparam int CLAMP_W = 13;
  localparam int MSB_W = 4;
  localparam int MSB_BIAS = 9;
  localparam int EXP_W = 5;
  localparam int L2_W = EXP_W + LOG_Q_W;
  localparam int X_W = 18;
  localparam int LOG10_2_Q16 = 19728;
  localparam logic signed [CHL_W-1:0] CHL_LOW_RAW = 16'sd102;
  localparam logic signed [CHL_W-1:0] CHL_CLAMP_RAW = 16'sd5120;

  // limit polynomial coefficients in Q32
  localparam int CF0_W = 26;
  localparam int CF1_W = 25;
  localparam int CF2_W = 22;
  localparam int CF3_W = 21;
  localparam logic signed [CF0_W-1:0] CF0 = 26'sd14216342;
  localparam logic signed [CF1_W-1:0] CF1 = 25'sd9113921;
  localparam logic signed [CF2_W-1:0] CF2 = 22'sd1356651;
  localparam logic signed [CF3_W-1:0] CF3 = 21'sd994070;
  localparam int T2_W = 23;
  localparam int T1_W = 26;
  localparam int LIM_W = 26;

  // scaled limit and divider formats
  localparam int PCT_SCALE = 25600;
  localparam int PCT_W = 15;
  localparam int D_W = (LIM_W - 1) + PCT_W;
  localparam int RRS_SHIFT = 13;
  localparam int DVD_W = D_W - RRS_SHIFT;
  localparam int DVS_W = 15;
  localparam int DIV_STEP = 3;
  localparam int DIV_STAGES = DVD_W / DIV_STEP;
  localparam int Q_W = DVD_W + 2;

  // output codes
  localparam int SAT_LO = -8388608;
  localparam logic signed [VAL_W-1:0] VAL_BAD = -24'sd255744;
  localparam logic signed [VAL_W-1:0] VAL_LOW = -24'sd25600;

  typedef enum logic [1:0] {
    ST_VALID = 2'd0,
    ST_FAIL  = 2'd1,
    ST_LOW   = 2'd2
  } status_e;

  // control that travels with an item between pipeline sections
  typedef struct packed {
    logic    valid;
    status_e status;
  } ctl_t;

  typedef logic [LOG_TABLE_ENTRIES-1:0][LOG_Q_W-1:0] log_rom_t;

  // entry i = log2(1 + i/N) in Q16, by repeated squaring of a Q30 value
  function automatic log_rom_t build_log_rom();
    log_rom_t rom;
    logic [63:0] v;
    logic [LOG_Q_W-1:0] acc;
    for (int i = 0; i < LOG_TABLE_ENTRIES; i++) begin
      v = (64'd1 << 30) + ((64'(i) << 30) / LOG_TABLE_ENTRIES);
      acc = '0;
      for (int b = 0; b < LOG_Q_W; b++) begin
        v = (v * v) >> 30;
        acc = {acc[LOG_Q_W-2:0], 1'b0};
        if (v >= (64'd2 << 30)) begin
          acc[0] = 1'b1;
          v = v >> 1;
        end
      end
      rom[i] = acc;
    end
    return rom;
  endfunction

  localparam log_rom_t LOG_ROM = build_log_rom();

endpackage

[hw/rtl/chl_rti_front.sv]
// front end: pixel classification, log2 by table, scaling to log10 in Q16
module chl_rti_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [chl_rti_pkg::CHL_W-1:0]   chl_value_i,
  input  logic signed [chl_rti_pkg::CHL_W-1:0]   green_rrs_i,
  input  logic                                   pixel_masked_i,
  output chl_rti_pkg::ctl_t                      ctl_o,
  output logic signed [chl_rti_pkg::X_W-1:0]     x_o,
  output logic        [chl_rti_pkg::DVS_W-1:0]   dvs_o,
  input  logic                                   out_ready_i
);
  import chl_rti_pkg::*;

  localparam int SH_W = CLAMP_W + LOG_Q_W;
  localparam int XM_W = L2_W + 17;

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  status_e st1_d, st1_q, st2_q, st3_q;
  logic [CLAMP_W-1:0] clamp_d;
  logic [MSB_W-1:0] msb1_d, msb1_q;
  logic [SH_W-1:0] frac_sh;
  logic [LOG_N_W+LOG_Q_W-1:0] idx_prod;
  logic [LOG_N_W-1:0] idx_wide;
  logic [LOG_IDX_W-1:0] idx1_d, idx1_q;
  logic [DVS_W-1:0] dvs1_q, dvs2_q, dvs3_q;
  logic [EXP_W-1:0] exp2_d;
  logic signed [L2_W-1:0] l2_d, l2_q;
  logic signed [XM_W-1:0] xm_d;
  logic signed [X_W-1:0] x_d, x_q;

  // stage enables: a stage loads when empty or when the next one moves
  assign en3 = !v3_q || out_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  // classify the pixel, clamp, find leading one and table index
  always_comb begin
    if (pixel_masked_i || (chl_value_i <= 16'sd0) || (green_rrs_i <= 16'sd0)) begin
      st1_d = ST_FAIL;
    end else if (chl_value_i <= CHL_LOW_RAW) begin
      st1_d = ST_LOW;
    end else begin
      st1_d = ST_VALID;
    end
    if (chl_value_i > CHL_CLAMP_RAW) begin
      clamp_d = CHL_CLAMP_RAW[CLAMP_W-1:0];
    end else begin
      clamp_d = chl_value_i[CLAMP_W-1:0];
    end
    msb1_d = '0;
    for (int k = 0; k < CLAMP_W; k++) begin
      if (clamp_d[k]) begin
        msb1_d = MSB_W'(k);
      end
    end
    frac_sh = {{LOG_Q_W{1'b0}}, clamp_d} << (5'(LOG_Q_W) - {1'b0, msb1_d});
    idx_prod = frac_sh[LOG_Q_W-1:0] * LOG_N_W'(LOG_TABLE_ENTRIES);
    idx_wide = idx_prod[LOG_Q_W +: LOG_N_W];
    if (idx_wide >= LOG_N_W'(LOG_TABLE_ENTRIES)) begin
      idx_wide = LOG_N_W'(LOG_TABLE_ENTRIES - 1);
    end
    idx1_d = idx_wide[LOG_IDX_W-1:0];
  end

  // log2 in Q16: exponent above the mantissa table entry
  assign exp2_d = {1'b0, msb1_q} - EXP_W'(MSB_BIAS);
  assign l2_d = {exp2_d, LOG_ROM[idx1_q]};

  // log10 = floor(log2 * log10(2))
  assign xm_d = l2_q * $signed({1'b0, 16'(LOG10_2_Q16)});
  assign x_d = $signed(xm_d[LOG_Q_W +: X_W]);

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en1) begin
      st1_q <= st1_d;
      msb1_q <= msb1_d;
      idx1_q <= idx1_d;
      dvs1_q <= green_rrs_i[DVS_W-1:0];
    end
    if (en2) begin
      st2_q <= st1_q;
      l2_q <= l2_d;
      dvs2_q <= dvs1_q;
    end
    if (en3) begin
      st3_q <= st2_q;
      x_q <= x_d;
      dvs3_q <= dvs2_q;
    end
  end

  assign ctl_o.valid = v3_q;
  assign ctl_o.status = st3_q;
  assign x_o = x_q;
  assign dvs_o = dvs3_q;

endmodule

[hw/rtl/chl_rti_poly.sv]
// horner evaluation of the cubic limit reflectance and its percent scaling
module chl_rti_poly (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  chl_rti_pkg::ctl_t                      ctl_i,
  input  logic signed [chl_rti_pkg::X_W-1:0]     x_i,
  input  logic        [chl_rti_pkg::DVS_W-1:0]   dvs_i,
  output logic                                   in_ready_o,
  output chl_rti_pkg::ctl_t                      ctl_o,
  output logic        [chl_rti_pkg::DVD_W-1:0]   dvd_o,
  output logic                                   sticky_o,
  output logic        [chl_rti_pkg::DVS_W-1:0]   dvs_o,
  input  logic                                   out_ready_i
);
  import chl_rti_pkg::*;

  localparam int M3_W = X_W + CF3_W;
  localparam int M2_W = X_W + T2_W;
  localparam int M1_W = X_W + T1_W;

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  status_e st1_q, st2_q, st3_q, st4_q;
  logic [DVS_W-1:0] dvs1_q, dvs2_q, dvs3_q, dvs4_q;
  logic signed [X_W-1:0] x1_q, x2_q;
  logic signed [M3_W-1:0] m3_d;
  logic signed [M2_W-1:0] m2_d;
  logic signed [M1_W-1:0] m1_d;
  logic signed [T2_W-1:0] t2_d, t2_q;
  logic signed [T1_W-1:0] t1_d, t1_q;
  logic signed [LIM_W-1:0] lim_d, lim_q;
  logic [D_W-1:0] scaled_d;
  logic [DVD_W-1:0] dvd_q;
  logic sticky_q;

  assign en4 = !v4_q || out_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  // t2 = c2 - x*c3
  assign m3_d = x_i * CF3;
  assign t2_d = T2_W'(CF2 - $signed(m3_d[M3_W-1:16]));
  // t1 = c1 + x*t2
  assign m2_d = x1_q * t2_q;
  assign t1_d = T1_W'(CF1 + $signed(m2_d[M2_W-1:16]));
  // lim = c0 + x*t1, always positive over the clamped range
  assign m1_d = x2_q * t1_q;
  assign lim_d = LIM_W'(CF0 + $signed(m1_d[M1_W-1:16]));
  // scale by 100 percent in 1/256, drop the reflectance alignment bits
  assign scaled_d = lim_q[LIM_W-2:0] * PCT_W'(PCT_SCALE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= ctl_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      st1_q <= ctl_i.status;
      dvs1_q <= dvs_i;
      x1_q <= x_i;
      t2_q <= t2_d;
    end
    if (en2) begin
      st2_q <= st1_q;
      dvs2_q <= dvs1_q;
      x2_q <= x1_q;
      t1_q <= t1_d;
    end
    if (en3) begin
      st3_q <= st2_q;
      dvs3_q <= dvs2_q;
      lim_q <= lim_d;
    end
    if (en4) begin
      st4_q <= st3_q;
      dvs4_q <= dvs3_q;
      dvd_q <= scaled_d[D_W-1:RRS_SHIFT];
      sticky_q <= |scaled_d[RRS_SHIFT-1:0];
    end
  end

  assign ctl_o.valid = v4_q;
  assign ctl_o.status = st4_q;
  assign dvd_o = dvd_q;
  assign sticky_o = sticky_q;
  assign dvs_o = dvs4_q;

endmodule

[hw/rtl/chl_rti_div.sv]
// pipelined restoring divider, three quotient bits per stage
module chl_rti_div (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  chl_rti_pkg::ctl_t                      ctl_i,
  input  logic        [chl_rti_pkg::DVD_W-1:0]   dvd_i,
  input  logic                                   sticky_i,
  input  logic        [chl_rti_pkg::DVS_W-1:0]   dvs_i,
  output logic                                   in_ready_o,
  output chl_rti_pkg::ctl_t                      ctl_o,
  output logic        [chl_rti_pkg::DVD_W-1:0]   quo_o,
  output logic                                   inexact_o,
  input  logic                                   out_ready_i
);
  import chl_rti_pkg::*;

  typedef struct packed {
    logic [DVS_W-1:0] rem;
    logic [DVD_W-1:0] acc;
  } div_st_t;

  // shift dividend bits out of acc, quotient bits in from the bottom
  function automatic div_st_t div_steps(input logic [DVD_W-1:0] acc,
                                        input logic [DVS_W-1:0] rem,
                                        input logic [DVS_W-1:0] dvs);
    div_st_t s;
    logic [DVS_W:0] trial;
    s.acc = acc;
    s.rem = rem;
    for (int b = 0; b < DIV_STEP; b++) begin
      trial = {s.rem, s.acc[DVD_W-1]};
      s.acc = {s.acc[DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        trial = trial - {1'b0, dvs};
        s.acc[0] = 1'b1;
      end
      s.rem = trial[DVS_W-1:0];
    end
    return s;
  endfunction

  logic v_q [DIV_STAGES];
  logic v_src [DIV_STAGES];
  logic en [DIV_STAGES+1];
  status_e st_q [DIV_STAGES];
  status_e st_src [DIV_STAGES];
  logic sticky_q [DIV_STAGES];
  logic sticky_src [DIV_STAGES];
  logic [DVS_W-1:0] dvs_q [DIV_STAGES];
  logic [DVS_W-1:0] dvs_src [DIV_STAGES];
  logic [DVS_W-1:0] rem_q [DIV_STAGES];
  logic [DVD_W-1:0] acc_q [DIV_STAGES];
  div_st_t step_d [DIV_STAGES];

  // enable chain and per-stage step logic
  always_comb begin
    en[DIV_STAGES] = out_ready_i;
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_src[0] = ctl_i.valid;
    st_src[0] = ctl_i.status;
    sticky_src[0] = sticky_i;
    dvs_src[0] = dvs_i;
    step_d[0] = div_steps(dvd_i, '0, dvs_i);
    for (int k = 1; k < DIV_STAGES; k++) begin
      v_src[k] = v_q[k-1];
      st_src[k] = st_q[k-1];
      sticky_src[k] = sticky_q[k-1];
      dvs_src[k] = dvs_q[k-1];
      step_d[k] = div_steps(acc_q[k-1], rem_q[k-1], dvs_q[k-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        v_q[k] <= 1'b0;
      end
    end else begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        if (en[k]) v_q[k] <= v_src[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (en[k]) begin
        st_q[k] <= st_src[k];
        sticky_q[k] <= sticky_src[k];
        dvs_q[k] <= dvs_src[k];
        rem_q[k] <= step_d[k].rem;
        acc_q[k] <= step_d[k].acc;
      end
    end
  end

  assign in_ready_o = en[0];
  assign ctl_o.valid = v_q[DIV_STAGES-1];
  assign ctl_o.status = st_q[DIV_STAGES-1];
  assign quo_o = acc_q[DIV_STAGES-1];
  assign inexact_o = sticky_q[DIV_STAGES-1] || (rem_q[DIV_STAGES-1] != '0);

`ifndef SYNTH
  // a finished valid-status item leaves a remainder below its divisor
  a_rem_below_dvs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[DIV_STAGES-1] && (st_q[DIV_STAGES-1] == ST_VALID))
      |-> (rem_q[DIV_STAGES-1] < dvs_q[DIV_STAGES-1]))
    else $error("divider remainder not below divisor");

  // an empty first stage always takes an item
  a_empty_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[0] |-> in_ready_o)
    else $error("divider refuses an item with its first stage empty");
`endif

endmodule

[hw/rtl/chl_reflectance_turbidity_index.sv]
// top level of the turbidity index pipeline with its output register
// One pixel enters per cycle while in_stall_o is low. In order, 3 stages
// classify the pixel and form log10 of the clamped chlorophyll from a 256-entry
// log2 table, 4 stages run the Horner steps of the limit polynomial and scale
// it, 9 stages of a restoring divider (3 quotient bits each) divide by the green
// reflectance, and one output register makes the final rounding, saturation and
// special-case selection. Every stage has its own valid bit, so a stall on the
// output only holds the input off once all stages are full; empty stages keep
// filling meanwhile. Masked or non-positive pixels give -999 percent with
// failure status, low chlorophyll gives -100 percent; values are in 1/256 percent.
module chl_reflectance_turbidity_index (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [chl_rti_pkg::CHL_W-1:0]   chl_value_i,
  input  logic signed [chl_rti_pkg::CHL_W-1:0]   green_rrs_i,
  input  logic                                   pixel_masked_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [chl_rti_pkg::VAL_W-1:0]   index_value_o,
  output logic        [1:0]                      index_status_o
);
  import chl_rti_pkg::*;

  ctl_t front_ctl, poly_ctl, div_ctl;
  logic front_ready, poly_ready, div_ready;
  logic signed [X_W-1:0] front_x;
  logic [DVS_W-1:0] front_dvs, poly_dvs;
  logic [DVD_W-1:0] poly_dvd, div_quo;
  logic poly_sticky, div_inexact;

  logic en_out;
  logic out_valid_q;
  logic signed [VAL_W-1:0] val_d, val_q;
  status_e st_q;
  logic signed [Q_W-1:0] base_d, q_d;

  chl_rti_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (front_ready),
    .chl_value_i   (chl_value_i),
    .green_rrs_i   (green_rrs_i),
    .pixel_masked_i(pixel_masked_i),
    .ctl_o         (front_ctl),
    .x_o           (front_x),
    .dvs_o         (front_dvs),
    .out_ready_i   (poly_ready)
  );

  chl_rti_poly u_poly (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (front_ctl),
    .x_i        (front_x),
    .dvs_i      (front_dvs),
    .in_ready_o (poly_ready),
    .ctl_o      (poly_ctl),
    .dvd_o      (poly_dvd),
    .sticky_o   (poly_sticky),
    .dvs_o      (poly_dvs),
    .out_ready_i(div_ready)
  );

  chl_rti_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (poly_ctl),
    .dvd_i      (poly_dvd),
    .sticky_i   (poly_sticky),
    .dvs_i      (poly_dvs),
    .in_ready_o (div_ready),
    .ctl_o      (div_ctl),
    .quo_o      (div_quo),
    .inexact_o  (div_inexact),
    .out_ready_i(en_out)
  );

  assign en_out = !out_valid_q || !out_stall_i;
  assign in_stall_o = !front_ready;

  // 100% minus scaled limit over reflectance, truncated toward zero
  always_comb begin
    base_d = Q_W'(PCT_SCALE) - $signed({2'b00, div_quo});
    if (div_inexact && (base_d > 0)) begin
      q_d = base_d - Q_W'(1);
    end else begin
      q_d = base_d;
    end
    case (div_ctl.status)
      ST_FAIL: val_d = VAL_BAD;
      ST_LOW:  val_d = VAL_LOW;
      default: begin
        if (q_d < Q_W'(SAT_LO)) begin
          val_d = VAL_W'(SAT_LO);
        end else begin
          val_d = q_d[VAL_W-1:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_out) begin
      out_valid_q <= div_ctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      val_q <= val_d;
      st_q <= div_ctl.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign index_value_o = val_q;
  assign index_status_o = st_q;

`ifndef SYNTH
  // the input is held off only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  // a valid index never exceeds 100 percent
  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (index_status_o == ST_VALID)) |-> (index_value_o <= 24'sd25600))
    else $error("valid index above 100 percent");
`endif

endmodule
